@@ src/jss_pkg.sv @@
package jss_pkg;

    localparam int DATA_W     = 32;
    localparam int POS_W      = 8;
    localparam int GRID_CFG_W = 9;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [POS_W-1:0]         pos_t;

    // item codes
    localparam logic OP_GRID  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // register indexes
    localparam logic CFG_GRID_SIZE    = 1'b0;
    localparam logic CFG_STEP_SQUARED = 1'b1;

    localparam int                GRID_SIZE_RESET = 256;
    localparam logic [DATA_W-1:0] STEP_SQ_RESET   = 32'd65027;

endpackage

@@ src/jacobi_stencil_sweep_top.sv @@
// Jacobi sweep of the 2D Poisson five-point stencil, streamed in raster order.
// Input channel (in_valid / in_stall): one word per grid point, opcode grid,
// carrying the current iterate and the source term in Q16.16. After all n*n
// points, send n+1 flush words (opcode flush) to drain the remaining results.
// Output channel (out_valid / out_stall): one word per grid point with the new
// value, its row and column, and last on the final point of the sweep.
// Throughput: one word per cycle on both sides while out_stall is low. The result
// for point k is in the output register in the cycle after word k+n+1 (or the
// flush that stands in for it) is taken. Three line buffers of MAX_GRID entries,
// one write and one read each per counted word, hold two window rows and the
// source terms; the 33x32 multiply and five-way add precede the result register.
// Configuration: cfg_write with cfg_index 0 sets the grid size (clamped to
// 2..MAX_GRID) and restarts the sweep; index 1 sets h squared (Q0.32).
// Reset: grid size 256, h squared 65027, sweep counters cleared, no result
// pending. The line buffers need no clearing pass: an entry read before it is
// written within a sweep feeds only an edge-masked tap or an unemitted point.
// Stall: while a result waits and out_stall is high, in_stall is high and
// nothing inside advances but what a configuration write changes.
module jacobi_stencil_sweep_top #(
    parameter int MAX_GRID = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [jss_pkg::DATA_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  jss_pkg::q16_t              point_value,
    input  jss_pkg::q16_t              source_term,
    output logic                       out_valid,
    input  logic                       out_stall,
    output jss_pkg::q16_t              new_value,
    output jss_pkg::pos_t              row_index,
    output jss_pkg::pos_t              column_index,
    output logic                       last
);
    import jss_pkg::*;

    localparam int IDX_W   = $clog2(MAX_GRID);
    localparam int N_RESET = (GRID_SIZE_RESET > MAX_GRID) ? MAX_GRID : GRID_SIZE_RESET;

    // configuration
    logic [IDX_W-1:0]  n_m1_reg, n_m1_next;
    logic [DATA_W-1:0] step_sq_reg, step_sq_next;
    logic [31:0]       gs_raw;
    logic [31:0]       gs_clamped;

    // sweep position
    logic [IDX_W-1:0] in_row_reg, in_row_next;
    logic [IDX_W-1:0] in_col_reg, in_col_next;
    logic [IDX_W-1:0] out_row_reg, out_row_next;
    logic [IDX_W-1:0] out_col_reg, out_col_next;
    logic             full_reg, full_next;

    // window storage
    q16_t line1_mem [MAX_GRID];
    q16_t line2_mem [MAX_GRID];
    q16_t src_mem   [MAX_GRID];
    q16_t line1_q_reg;
    q16_t line2_q_reg;
    q16_t src_q_reg;
    q16_t tap1_reg;
    q16_t tap2_reg;
    q16_t src_d_reg;
    q16_t prev_u_reg;

    // result register
    logic out_valid_reg, out_valid_next;
    q16_t new_value_reg;
    pos_t row_reg;
    pos_t col_reg;
    logic last_reg;

    logic             in_fire;
    logic             step;
    logic             primed;
    logic             emit;
    logic             col_wrap;
    logic [IDX_W-1:0] next_col;
    logic             out_last;

    logic signed [64:0] prod;
    logic signed [64:0] prod_rnd;
    logic signed [32:0] p16;
    q16_t               up_v;
    q16_t               down_v;
    q16_t               left_v;
    q16_t               right_v;
    logic signed [34:0] sum;
    q16_t               sat_v;
    logic signed [33:0] quarter;
    q16_t               result_v;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // a grid word counts until the grid is full, a flush word only after that
    assign step     = in_fire && ((opcode == OP_FLUSH) ? full_reg : !full_reg);
    assign primed   = (in_row_reg > IDX_W'(1)) ||
                      ((in_row_reg == IDX_W'(1)) && (in_col_reg != '0));
    assign emit     = step && (full_reg || primed);
    assign col_wrap = (in_col_reg == n_m1_reg);
    assign next_col = col_wrap ? '0 : in_col_reg + IDX_W'(1);
    assign out_last = (out_row_reg == n_m1_reg) && (out_col_reg == n_m1_reg);

    // clamp the grid size on write
    always_comb
    begin
        gs_raw = 32'(cfg_data[GRID_CFG_W-1:0]);
        priority if (gs_raw < 32'd2)
        begin
            gs_clamped = 32'd2;
        end
        else if (gs_raw > 32'(MAX_GRID))
        begin
            gs_clamped = 32'(MAX_GRID);
        end
        else
        begin
            gs_clamped = gs_raw;
        end
    end

    // stencil arithmetic on the window taps of point k
    always_comb
    begin
        prod     = $signed({1'b0, step_sq_reg}) * src_d_reg;
        prod_rnd = prod + 65'sd2147483648;
        p16      = $signed(prod_rnd[64:32]);
        up_v     = (out_row_reg != '0)       ? line2_q_reg : '0;
        down_v   = (out_row_reg != n_m1_reg) ? prev_u_reg  : '0;
        left_v   = (out_col_reg != '0)       ? tap2_reg    : '0;
        right_v  = (out_col_reg != n_m1_reg) ? line1_q_reg : '0;
        sum      = 35'(p16) + 35'(up_v) + 35'(down_v) + 35'(left_v) + 35'(right_v);
        priority if (sum > 35'sd2147483647)
        begin
            sat_v = 32'sh7fff_ffff;
        end
        else if (sum < -35'sd2147483648)
        begin
            sat_v = 32'sh8000_0000;
        end
        else
        begin
            sat_v = q16_t'(sum[31:0]);
        end
        quarter  = 34'(sat_v) + 34'sd2;
        result_v = $signed(quarter[33:2]);
    end

    always_comb
    begin
        n_m1_next      = n_m1_reg;
        step_sq_next   = step_sq_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && out_stall;

        priority if (cfg_write)
        begin
            if (cfg_index == CFG_GRID_SIZE)
            begin
                n_m1_next    = IDX_W'(gs_clamped - 32'd1);
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                full_next    = 1'b0;
            end
            else
            begin
                step_sq_next = cfg_data;
            end
        end
        else if (step)
        begin
            in_col_next = next_col;
            if (!full_reg && col_wrap)
            begin
                if (in_row_reg == n_m1_reg)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + IDX_W'(1);
                end
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                if (out_col_reg == n_m1_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + IDX_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + IDX_W'(1);
                end
                // end of sweep: start over at point zero
                if (out_last)
                begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                    full_next    = 1'b0;
                end
            end
        end
        else
        begin
            // no counted word this cycle: hold
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_m1_reg      <= IDX_W'(N_RESET - 1);
            step_sq_reg   <= STEP_SQ_RESET;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_m1_reg      <= n_m1_next;
            step_sq_reg   <= step_sq_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line buffers: write this column, read ahead the next one
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            line1_mem[in_col_reg] <= point_value;
            line2_mem[in_col_reg] <= tap1_reg;
            src_mem[in_col_reg]   <= source_term;
            line1_q_reg           <= line1_mem[next_col];
            line2_q_reg           <= line2_mem[next_col];
            src_q_reg             <= src_mem[next_col];
            tap1_reg              <= line1_q_reg;
            tap2_reg              <= tap1_reg;
            src_d_reg             <= src_q_reg;
            prev_u_reg            <= point_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            new_value_reg <= result_v;
            row_reg       <= POS_W'(out_row_reg);
            col_reg       <= POS_W'(out_col_reg);
            last_reg      <= out_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_value    = new_value_reg;
    assign row_index    = row_reg;
    assign column_index = col_reg;
    assign last         = last_reg;

endmodule

@@ src/jss_checker.sv @@
module jss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input jss_pkg::q16_t              new_value,
    input jss_pkg::pos_t              row_index,
    input jss_pkg::pos_t              column_index,
    input logic                       last
);
    import jss_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_value) &&
            $stable(row_index) && $stable(column_index) && $stable(last))
        else $error("stalled result word changed");

    // input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // the grid is square, so the final point sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> row_index == column_index)
        else $error("last result off the diagonal");

    // every fresh result follows a taken input word
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && out_stall) |-> $past(in_valid && !in_stall))
        else $error("result word without an input word");

endmodule

bind jacobi_stencil_sweep_top jss_checker u_jss_checker (.*);
